>>> sv/tcce_pkg.sv
// Shared types and codes for the text console character engine.
// No dependencies; used by every file of the block.
`default_nettype none

package tcce_pkg;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_FLUSH,
    ST_PUT
  } state_t;

  // What follows the end of a store sweep
  typedef enum logic [1:0] {
    JOB_INIT,
    JOB_CLEAR,
    JOB_NEWLINE,
    JOB_PUT
  } job_t;

  typedef enum logic {
    REG_TEXT_FG = 1'b0,
    REG_TEXT_BG = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [3:0] fg;
    logic [3:0] bg;
  } cell_t;

  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  localparam logic [3:0] DEFAULT_FG = 4'd7;
  localparam logic [3:0] DEFAULT_BG = 4'd0;

endpackage

`default_nettype wire

>>> sv/tcce_screen_ram.sv
// Screen store: one write port, one read port, registered read data.
// Uses tcce_pkg::cell_t.
`default_nettype none

module tcce_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  wire                 clk,
  input  wire                 we,
  input  wire [AW-1:0]        waddr,
  input  tcce_pkg::cell_t     wdata,
  input  wire [AW-1:0]        raddr,
  output tcce_pkg::cell_t     rdata
);

  tcce_pkg::cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/text_console_character_engine.sv
// Text console character engine: screen store, cursor and command sequencer.
// Depends on tcce_pkg and tcce_screen_ram.
//
//   channel   handshake                  payload
//   command   start / busy               cmd, char_code, cell_fg, cell_bg,
//                                        cell_row, cell_column
//   result    done (one-cycle strobe)    read_char, read_fg, read_bg,
//                                        cursor_row, cursor_column
//   config    write_enable               write_index, write_data
//
// Put character (no scroll), tab, newline and cell write: done in the cycle after
// start. Cell read: done after the ST_READ state (one store read). Scroll and clear sweep the
// store at one cell per cycle, then pass ST_FLUSH, and ST_PUT when a character
// follows the scroll. After reset, busy stays high while the store is blanked.
// Results cannot be stalled.
`default_nettype none

module text_console_character_engine #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  output logic       busy,
  input  wire [1:0]  cmd,
  input  wire [7:0]  char_code,
  input  wire [3:0]  cell_fg,
  input  wire [3:0]  cell_bg,
  input  wire [4:0]  cell_row,
  input  wire [6:0]  cell_column,
  output logic       done,
  output logic [7:0] read_char,
  output logic [3:0] read_fg,
  output logic [3:0] read_bg,
  output logic [4:0] cursor_row,
  output logic [6:0] cursor_column,
  input  wire        write_enable,
  input  wire        write_index,
  input  wire [3:0]  write_data
);

  localparam int CELLS   = ROWS * COLUMNS;
  localparam int SHIFT   = (ROWS - 1) * COLUMNS;
  localparam int AW      = $clog2(CELLS);
  localparam int RW      = $clog2(ROWS + 1);
  localparam int CW      = $clog2(COLUMNS + 1);
  localparam int TAB_MAX = COLUMNS / TAB_STOP + 1;

  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] SHIFT_CELL = AW'(SHIFT);
  localparam logic [AW-1:0] ROW_CELLS  = AW'(COLUMNS);
  localparam logic [RW:0]   ROW_LIM    = (RW + 1)'(ROWS);
  localparam logic [RW-1:0] ROW_LAST   = RW'(ROWS - 1);
  localparam logic [RW-1:0] ROW_END    = RW'(ROWS);
  localparam logic [CW-1:0] COL_LIM    = CW'(COLUMNS);
  localparam logic [CW-1:0] TAB_LIM    = CW'(COLUMNS - TAB_STOP);

  tcce_pkg::state_t state, state_next;
  tcce_pkg::job_t   job;

  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [3:0]    text_fg;
  logic [3:0]    text_bg;

  logic [AW-1:0]   cnt;
  logic            sweep_copy;
  tcce_pkg::cell_t blank;
  logic            cp_valid;
  logic [AW-1:0]   cp_addr;
  logic            cp_blank;
  logic [7:0]      put_ch;
  logic            rd_ok;
  logic            done_next;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  tcce_pkg::cell_t ram_wdata;
  logic [AW-1:0]   ram_raddr;
  tcce_pkg::cell_t ram_rdata;

  // Decode of the command at the port
  logic          accept;
  logic          in_range;
  logic [AW-1:0] in_addr;
  logic          is_tab;
  logic          is_nl;
  logic          tab_nl;
  logic          as_newline;
  logic [CW-1:0] tab_col;
  logic          wrap;
  logic [RW:0]   row_w;
  logic [CW-1:0] col_w;
  logic          pend_scroll;
  logic          put_scroll;
  logic          needs_scroll;
  logic [AW-1:0] cur_addr;

  assign busy   = (state != tcce_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign in_range = (cell_row < 5'(ROWS)) && (cell_column < 7'(COLUMNS));
  assign in_addr  = AW'(int'(cell_row) * COLUMNS + int'(cell_column));

  assign is_tab     = (char_code == tcce_pkg::CH_TAB);
  assign is_nl      = (char_code == tcce_pkg::CH_NEWLINE);
  assign tab_nl     = (cur_col > TAB_LIM);
  assign as_newline = is_nl || (is_tab && tab_nl);

  // next tab stop: smallest multiple of TAB_STOP above the column
  always_comb begin
    tab_col = '0;
    for (int m = TAB_MAX; m >= 1; m--) begin
      if (m * TAB_STOP > int'(cur_col)) begin
        tab_col = CW'(m * TAB_STOP);
      end
    end
  end

  assign wrap         = (cur_col >= COL_LIM);
  assign row_w        = wrap ? ({1'b0, cur_row} + 1'b1) : {1'b0, cur_row};
  assign col_w        = wrap ? '0 : cur_col;
  assign pend_scroll  = (cur_row >= ROW_END);
  assign put_scroll   = (row_w >= ROW_LIM);
  assign needs_scroll = as_newline ? pend_scroll : (!is_tab && put_scroll);
  assign cur_addr     = AW'(int'(row_w) * COLUMNS + int'(col_w));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tcce_pkg::ST_IDLE: begin
        if (accept) begin
          case (tcce_pkg::cmd_t'(cmd))
            tcce_pkg::CMD_READ:  state_next = tcce_pkg::ST_READ;
            tcce_pkg::CMD_CLEAR: state_next = tcce_pkg::ST_SWEEP;
            tcce_pkg::CMD_PUT: begin
              if (needs_scroll) begin
                state_next = tcce_pkg::ST_SWEEP;
              end
            end
            default: state_next = tcce_pkg::ST_IDLE;
          endcase
        end
      end
      tcce_pkg::ST_READ:  state_next = tcce_pkg::ST_IDLE;
      tcce_pkg::ST_SWEEP: begin
        if (cnt == LAST_CELL) begin
          state_next = tcce_pkg::ST_FLUSH;
        end
      end
      tcce_pkg::ST_FLUSH: begin
        state_next = (job == tcce_pkg::JOB_PUT) ? tcce_pkg::ST_PUT : tcce_pkg::ST_IDLE;
      end
      tcce_pkg::ST_PUT:   state_next = tcce_pkg::ST_IDLE;
      default:            state_next = tcce_pkg::ST_IDLE;
    endcase
  end

  // Store port control and result strobe
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cp_addr;
    ram_wdata = cp_blank ? blank : ram_rdata;
    ram_raddr = in_addr;
    done_next = 1'b0;
    case (state)
      tcce_pkg::ST_IDLE: begin
        if (accept) begin
          case (tcce_pkg::cmd_t'(cmd))
            tcce_pkg::CMD_WRITE: begin
              ram_we    = in_range;
              ram_waddr = in_addr;
              ram_wdata = '{ch: char_code, fg: cell_fg, bg: cell_bg};
              done_next = 1'b1;
            end
            tcce_pkg::CMD_PUT: begin
              ram_we    = !is_tab && !is_nl && !put_scroll;
              ram_waddr = cur_addr;
              ram_wdata = '{ch: char_code, fg: text_fg, bg: text_bg};
              done_next = !needs_scroll;
            end
            default: done_next = 1'b0;
          endcase
        end
      end
      tcce_pkg::ST_READ: done_next = 1'b1;
      tcce_pkg::ST_SWEEP: begin
        ram_we = cp_valid;
        // source row sits one row ahead of the destination
        if (sweep_copy && cnt < SHIFT_CELL) begin
          ram_raddr = cnt + ROW_CELLS;
        end
      end
      tcce_pkg::ST_FLUSH: begin
        ram_we    = cp_valid;
        done_next = (job == tcce_pkg::JOB_CLEAR) || (job == tcce_pkg::JOB_NEWLINE);
      end
      tcce_pkg::ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = SHIFT_CELL;
        ram_wdata = '{ch: put_ch, fg: text_fg, bg: text_bg};
        done_next = 1'b1;
      end
      default: done_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tcce_pkg::ST_SWEEP;
      job        <= tcce_pkg::JOB_INIT;
      cnt        <= '0;
      sweep_copy <= 1'b0;
      blank      <= '{ch: tcce_pkg::CH_SPACE, fg: tcce_pkg::DEFAULT_FG,
                      bg: tcce_pkg::DEFAULT_BG};
      cp_valid   <= 1'b0;
      cur_row    <= '0;
      cur_col    <= '0;
      text_fg    <= tcce_pkg::DEFAULT_FG;
      text_bg    <= tcce_pkg::DEFAULT_BG;
      done       <= 1'b0;
    end else begin
      state    <= state_next;
      done     <= done_next;
      cp_valid <= (state == tcce_pkg::ST_SWEEP);

      if (write_enable) begin
        case (tcce_pkg::reg_index_t'(write_index))
          tcce_pkg::REG_TEXT_FG: text_fg <= write_data;
          tcce_pkg::REG_TEXT_BG: text_bg <= write_data;
          default: ;
        endcase
      end

      if (state == tcce_pkg::ST_SWEEP) begin
        cnt <= cnt + 1'b1;
      end

      if (accept) begin
        cnt        <= '0;
        blank      <= '{ch: tcce_pkg::CH_SPACE, fg: text_fg, bg: text_bg};
        sweep_copy <= (tcce_pkg::cmd_t'(cmd) == tcce_pkg::CMD_PUT);
        case (tcce_pkg::cmd_t'(cmd))
          tcce_pkg::CMD_CLEAR: begin
            job     <= tcce_pkg::JOB_CLEAR;
            cur_row <= '0;
            cur_col <= '0;
          end
          tcce_pkg::CMD_PUT: begin
            if (as_newline) begin
              job     <= tcce_pkg::JOB_NEWLINE;
              cur_col <= '0;
              cur_row <= pend_scroll ? ROW_END : (cur_row + 1'b1);
            end else if (is_tab) begin
              cur_col <= tab_col;
            end else if (put_scroll) begin
              job     <= tcce_pkg::JOB_PUT;
              cur_row <= ROW_LAST;
              cur_col <= CW'(1);
            end else begin
              cur_row <= row_w[RW-1:0];
              cur_col <= col_w + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cp_addr  <= cnt;
    cp_blank <= !sweep_copy || (cnt >= SHIFT_CELL);
    if (accept) begin
      put_ch    <= char_code;
      rd_ok     <= in_range;
      read_char <= '0;
      read_fg   <= '0;
      read_bg   <= '0;
    end
    if (state == tcce_pkg::ST_READ && rd_ok) begin
      read_char <= ram_rdata.ch;
      read_fg   <= ram_rdata.fg;
      read_bg   <= ram_rdata.bg;
    end
  end

  assign cursor_row    = 5'(cur_row);
  assign cursor_column = 7'(cur_col);

  tcce_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for text_console_character_engine: command driver,
// result checker with its own screen and cursor predictor, color register writes.
// Depends on tcce_pkg and the engine RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int COLS        = 80;
  localparam int ROWS        = 25;
  localparam int TAB         = 8;
  localparam int QUIET_LIMIT = 8000;

  typedef struct {
    tcce_pkg::cmd_t op;
    logic [7:0]     ch;
    logic [3:0]     fg;
    logic [3:0]     bg;
    logic [4:0]     row;
    logic [6:0]     col;
  } command_t;

  typedef struct packed {
    tcce_pkg::cell_t glyph;
    logic [4:0]      row;
    logic [6:0]      col;
  } view_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  tcce_pkg::cmd_t       cmd = tcce_pkg::CMD_PUT;
  logic [7:0]           char_code = '0;
  logic [3:0]           cell_fg = '0;
  logic [3:0]           cell_bg = '0;
  logic [4:0]           cell_row = '0;
  logic [6:0]           cell_column = '0;
  logic                 write_enable = 1'b0;
  tcce_pkg::reg_index_t write_index = tcce_pkg::REG_TEXT_FG;
  logic [3:0]           write_data = '0;

  wire       busy;
  wire       done;
  wire [7:0] read_char;
  wire [3:0] read_fg;
  wire [3:0] read_bg;
  wire [4:0] cursor_row;
  wire [6:0] cursor_column;

  // predictor state
  tcce_pkg::cell_t screen_img [ROWS*COLS];
  int              cur_r = 0;
  int              cur_c = 0;
  logic [3:0]      ink_fg = tcce_pkg::DEFAULT_FG;
  logic [3:0]      ink_bg = tcce_pkg::DEFAULT_BG;

  command_t command_fifo [$];
  view_t    expected_views [$];
  int       idle_pct = 19;
  int       sent = 0;
  int       taken = 0;
  int       mismatches = 0;
  int       quiet = 0;

  text_console_character_engine #(
    .COLUMNS (COLS),
    .ROWS    (ROWS),
    .TAB_STOP(TAB)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .char_code    (char_code),
    .cell_fg      (cell_fg),
    .cell_bg      (cell_bg),
    .cell_row     (cell_row),
    .cell_column  (cell_column),
    .done         (done),
    .read_char    (read_char),
    .read_fg      (read_fg),
    .read_bg      (read_bg),
    .cursor_row   (cursor_row),
    .cursor_column(cursor_column),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  always #6 clk = ~clk;

  function automatic void blank_all();
    for (int i = 0; i < ROWS*COLS; i++) screen_img[i] = {tcce_pkg::CH_SPACE, ink_fg, ink_bg};
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < (ROWS-1)*COLS; i++) screen_img[i] = screen_img[i+COLS];
    for (int i = (ROWS-1)*COLS; i < ROWS*COLS; i++)
      screen_img[i] = {tcce_pkg::CH_SPACE, ink_fg, ink_bg};
  endfunction

  // a pending scroll is taken first, so the row never goes past ROWS
  function automatic void line_feed();
    if (cur_r >= ROWS) begin
      scroll_screen();
      cur_r = ROWS - 1;
    end
    cur_c = 0;
    cur_r++;
  endfunction

  function automatic view_t apply_command(command_t c);
    view_t v;
    bit    in_range;
    int    idx;
    v = '0;
    in_range = (int'(c.row) < ROWS) && (int'(c.col) < COLS);
    idx = int'(c.row) * COLS + int'(c.col);
    case (c.op)
      tcce_pkg::CMD_PUT: begin
        if (c.ch == tcce_pkg::CH_TAB) begin
          if (cur_c > COLS - TAB) line_feed();
          else cur_c += TAB - cur_c % TAB;
        end else if (c.ch == tcce_pkg::CH_NEWLINE) begin
          line_feed();
        end else begin
          if (cur_c >= COLS) begin
            cur_c = 0;
            cur_r++;
          end
          if (cur_r >= ROWS) begin
            scroll_screen();
            cur_c = 0;
            cur_r = ROWS - 1;
          end
          screen_img[cur_r*COLS + cur_c] = {c.ch, ink_fg, ink_bg};
          cur_c++;
        end
      end
      tcce_pkg::CMD_WRITE: if (in_range) screen_img[idx] = {c.ch, c.fg, c.bg};
      tcce_pkg::CMD_READ:  if (in_range) v.glyph = screen_img[idx];
      default: begin
        blank_all();
        cur_r = 0;
        cur_c = 0;
      end
    endcase
    v.row = 5'(cur_r);
    v.col = 7'(cur_c);
    return v;
  endfunction

  function automatic void queue_cmd(tcce_pkg::cmd_t op, logic [7:0] ch, logic [3:0] fg,
                                    logic [3:0] bg, logic [4:0] row, logic [6:0] col);
    command_t c;
    c.op = op;
    c.ch = ch;
    c.fg = fg;
    c.bg = bg;
    c.row = row;
    c.col = col;
    command_fifo.push_back(c);
  endfunction

  // mostly typing, with direct writes, reads and rare clears so the cursor
  // gets to the bottom and keeps scrolling
  function automatic void queue_random(int n);
    command_t c;
    int       sel;
    int       k;
    for (int i = 0; i < n; i++) begin
      c.ch = 8'($urandom_range(0, 255));
      c.fg = 4'($urandom_range(0, 15));
      c.bg = 4'($urandom_range(0, 15));
      c.row = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(0, ROWS-1));
      c.col = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(0, COLS-1));
      sel = $urandom_range(0, 999);
      if (sel < 4) begin
        c.op = tcce_pkg::CMD_CLEAR;
      end else if (sel < 600) begin
        c.op = tcce_pkg::CMD_PUT;
        k = $urandom_range(0, 99);
        if (k < 20) c.ch = tcce_pkg::CH_NEWLINE;
        else if (k < 35) c.ch = tcce_pkg::CH_TAB;
      end else if (sel < 720) begin
        c.op = tcce_pkg::CMD_WRITE;
      end else begin
        c.op = tcce_pkg::CMD_READ;
        if ($urandom_range(0, 1) == 1) c.row = 5'($urandom_range(ROWS-3, ROWS-1));
      end
      command_fifo.push_back(c);
    end
  endfunction

  task automatic flag_mismatch(string what);
    if (mismatches < 100) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (command_fifo.size() != 0 || expected_views.size() != 0 || start || busy);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_colors(logic [3:0] fg, logic [3:0] bg);
    @(negedge clk);
    write_enable <= 1'b1;
    write_index  <= tcce_pkg::REG_TEXT_FG;
    write_data   <= fg;
    @(negedge clk);
    write_index  <= tcce_pkg::REG_TEXT_BG;
    write_data   <= bg;
    @(negedge clk);
    write_enable <= 1'b0;
    ink_fg = fg;
    ink_bg = bg;
  endtask

  // driver: a word stays on the bus until it is taken
  always @(negedge clk) begin : feed
    command_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken == sent) begin
      if (command_fifo.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt = command_fifo.pop_front();
        sent++;
        start       <= 1'b1;
        cmd         <= nxt.op;
        char_code   <= nxt.ch;
        cell_fg     <= nxt.fg;
        cell_bg     <= nxt.bg;
        cell_row    <= nxt.row;
        cell_column <= nxt.col;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: retire the oldest expectation before queuing a new one
  always @(posedge clk) begin : watch
    command_t got;
    view_t    want;
    if (rst) begin
      blank_all();
    end else begin
      if (done) begin
        if (expected_views.size() == 0) begin
          flag_mismatch("result word with nothing expected");
        end else begin
          want = expected_views.pop_front();
          if (read_char !== want.glyph.ch)
            flag_mismatch($sformatf("read_char %0d, expected %0d", read_char, want.glyph.ch));
          if (read_fg !== want.glyph.fg)
            flag_mismatch($sformatf("read_fg %0d, expected %0d", read_fg, want.glyph.fg));
          if (read_bg !== want.glyph.bg)
            flag_mismatch($sformatf("read_bg %0d, expected %0d", read_bg, want.glyph.bg));
          if (cursor_row !== want.row)
            flag_mismatch($sformatf("cursor_row %0d, expected %0d", cursor_row, want.row));
          if (cursor_column !== want.col)
            flag_mismatch($sformatf("cursor_column %0d, expected %0d",
                                    cursor_column, want.col));
        end
      end
      if (start && !busy) begin
        got.op = cmd;
        got.ch = char_code;
        got.fg = cell_fg;
        got.bg = cell_bg;
        got.row = cell_row;
        got.col = cell_column;
        expected_views.push_back(apply_command(got));
        taken++;
      end
    end
    if (done || (start && !busy)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("text_console_character_engine verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // reads and direct writes at the corners, out-of-range addresses,
    // tab stops up to the wrap column, tab past the last stop, clear
    queue_cmd(tcce_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0);
    queue_cmd(tcce_pkg::CMD_WRITE, 8'hFF, 4'hF, 4'hF, 5'd0, 7'd0);
    queue_cmd(tcce_pkg::CMD_WRITE, 8'h00, 4'h0, 4'h0, 5'(ROWS-1), 7'(COLS-1));
    queue_cmd(tcce_pkg::CMD_WRITE, 8'h55, 4'hA, 4'h5, 5'd31, 7'd0);
    queue_cmd(tcce_pkg::CMD_WRITE, 8'hAA, 4'h5, 4'hA, 5'd0, 7'd127);
    queue_cmd(tcce_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0);
    queue_cmd(tcce_pkg::CMD_READ, 8'hFF, 4'hF, 4'hF, 5'(ROWS-1), 7'(COLS-1));
    queue_cmd(tcce_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 5'(ROWS), 7'd0);
    queue_cmd(tcce_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'(COLS));
    queue_cmd(tcce_pkg::CMD_PUT, 8'h7F, 4'hF, 4'hF, 5'd31, 7'd127);
    repeat (10) queue_cmd(tcce_pkg::CMD_PUT, tcce_pkg::CH_TAB, 4'h0, 4'h0, 5'd0, 7'd0);
    queue_cmd(tcce_pkg::CMD_PUT, tcce_pkg::CH_TAB, 4'h0, 4'h0, 5'd0, 7'd0);
    queue_cmd(tcce_pkg::CMD_PUT, tcce_pkg::CH_NEWLINE, 4'h0, 4'h0, 5'd0, 7'd0);
    queue_cmd(tcce_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0);
    queue_cmd(tcce_pkg::CMD_CLEAR, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0);
    queue_cmd(tcce_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 5'(ROWS-1), 7'(COLS-1));
    wait_drained();

    set_colors(4'hF, 4'h0);
    idle_pct = 19;
    queue_random(420);
    wait_drained();

    set_colors(4'h0, 4'hF);
    idle_pct = 49;
    queue_random(420);
    wait_drained();

    set_colors(4'($urandom_range(1, 14)), 4'($urandom_range(1, 14)));
    idle_pct = 0;
    queue_random(410);
    wait_drained();

    // catch any stray strobe
    repeat (ROWS*COLS + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("text_console_character_engine verification clean");
    end else begin
      $display("text_console_character_engine verification failed");
    end
    $finish;
  end

endmodule
